// ----- hdl/srbs_pkg.sv -----
// ----------------------------------------------------------------------------
// srbs_pkg
// Shared types and codes for the shortest-remaining-burst scheduler.
// ----------------------------------------------------------------------------
package srbs_pkg;

    // Item kinds on the input tuser bit
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Fixed field widths of the stream payloads
    localparam int IN_DATA_W  = 72;   // 68 bits of fields, padded to bytes
    localparam int OUT_DATA_W = 56;   // 55 bits of fields, padded to bytes
    localparam int CFG_W      = 5;

    // Progress of one process through its two bursts
    typedef enum logic [1:0] {
        PH_FIRST  = 2'd0,
        PH_SECOND = 2'd1,
        PH_DONE   = 2'd2
    } phase_t;

    // Control from the sequencer to the selection unit
    typedef struct packed {
        logic clear;      // restart accumulation
        logic beat;       // one table entry is on the read port
        logic find_min;   // least arrival pass instead of selection pass
    } pick_ctl_t;

endpackage

// ----- hdl/srbs_ram.sv -----
// ----------------------------------------------------------------------------
// srbs_ram
// Generic synchronous RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module srbs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- hdl/srbs_pick.sv -----
// ----------------------------------------------------------------------------
// srbs_pick
// Selection unit: takes one table entry per beat and keeps the least
// arrival time, or the ready entry with the least remaining burst.
// ----------------------------------------------------------------------------
module srbs_pick
    import srbs_pkg::*;
#(
    parameter int TIME_BITS = 16,
    parameter int IDX_W     = 4,
    parameter int CNT_W     = 5
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  pick_ctl_t              ctl,
    input  logic [TIME_BITS-1:0]   now,
    input  logic [IDX_W-1:0]       idx,
    input  logic [4*TIME_BITS-1:0] entry,
    input  phase_t                 phase,
    input  logic                   started,
    output logic                   found,
    output logic [IDX_W-1:0]       best_idx,
    output logic [4*TIME_BITS-1:0] best_entry,
    output phase_t                 best_phase,
    output logic                   best_started,
    output logic [CNT_W-1:0]       unf_cnt,
    output logic [TIME_BITS-1:0]   min_ready
);

    localparam int TB = TIME_BITS;
    localparam logic [TB-1:0] TMAX = '1;

    logic [TB-1:0] e_ready;
    logic [TB-1:0] e_rem;
    logic [TB-1:0] best_rem;
    logic          take;

    // Remaining burst of the entry in its current phase
    assign e_ready = entry[TB-1:0];
    assign e_rem   = (phase == PH_FIRST) ? entry[2*TB-1:TB] : entry[3*TB-1:2*TB];
    assign take    = (phase != PH_DONE) && (e_ready <= now) &&
                     (!found || (e_rem < best_rem));

    // Accumulate over beats
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found        <= 1'b0;
            best_idx     <= '0;
            best_entry   <= '0;
            best_phase   <= PH_FIRST;
            best_started <= 1'b0;
            best_rem     <= '0;
            unf_cnt      <= '0;
            min_ready    <= TMAX;
        end else if (ctl.clear) begin
            found     <= 1'b0;
            unf_cnt   <= '0;
            min_ready <= TMAX;
        end else if (ctl.beat) begin
            if (ctl.find_min) begin
                if (e_ready < min_ready) begin
                    min_ready <= e_ready;
                end
            end else begin
                if (phase != PH_DONE) begin
                    unf_cnt <= unf_cnt + CNT_W'(1);
                end
                if (take) begin
                    found        <= 1'b1;
                    best_idx     <= idx;
                    best_entry   <= entry;
                    best_phase   <= phase;
                    best_started <= started;
                    best_rem     <= e_rem;
                end
            end
        end
    end

endmodule

// ----- hdl/shortest_remaining_burst_scheduler.sv -----
// ----------------------------------------------------------------------------
// shortest_remaining_burst_scheduler
// Preemptive shortest-remaining-burst scheduler over a process table.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one item per load or tick. s_tuser is the kind (0 load,
//   1 tick). A load writes one table entry in the accept cycle and gives no
//   result. A tick gives exactly one result item on the m_ channel.
//   cfg channel: writes process_count (always ready); the user must write it
//   only while the block is idle: the block itself does not enforce this.
// Operation:
//   A tick scans the n active entries through the table RAM read port,
//   one entry a cycle, then writes the chosen entry back and registers
//   its result; the next item is accepted only once the block is idle
//   again. The first tick after reset or a load first scans for the least
//   arrival time when n is not zero.
// Reset:
//   aresetn clears the phase and started flags, time and the output
//   register; process_count returns to 1. Table RAM contents are kept and
//   are defined only once loaded.
// Stalls:
//   The result sits in an output register; the next item is accepted while
//   it waits, and a tick only stalls at its final write when the previous
//   result has still not been taken.
// ----------------------------------------------------------------------------
module shortest_remaining_burst_scheduler
    import srbs_pkg::*;
#(
    parameter int MAX_PROCS = 16,
    parameter int TIME_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // slot, arrival_time, first_burst, io_wait, second_burst (from bit 0)
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // op
    input  logic                  s_tuser,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // tick_time, run_index, first_dispatch, response_time, finished,
    // finish_time, all_done (from bit 0)
    output logic [OUT_DATA_W-1:0] m_tdata,
    // idle
    output logic                  m_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // process_count
    input  logic [CFG_W-1:0]      cfg_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready
);

    localparam int TB    = TIME_BITS;
    localparam int IDX_W = $clog2(MAX_PROCS);
    localparam int CNT_W = $clog2(MAX_PROCS + 1);
    localparam int CW    = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int EW    = 4 * TB;
    localparam logic [TB-1:0] TMAX = '1;

    typedef enum logic [1:0] {S_IDLE, S_MIN, S_SCAN, S_UPD} state_t;

    // Saturate a 16-bit input time into the internal time width
    function automatic logic [TB-1:0] sat_in(input logic [15:0] v);
        logic [31:0] e;
        e = 32'(v);
        return (e > 32'(TMAX)) ? TMAX : e[TB-1:0];
    endfunction

    // Low 16 bits of an internal time
    function automatic logic [15:0] to16(input logic [TB-1:0] v);
        logic [31:0] e;
        e = 32'(v);
        return e[15:0];
    endfunction

    state_t                  state_reg, state_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic                    beat_reg, beat_next;
    logic [IDX_W-1:0]        beat_idx_reg, beat_idx_next;
    logic [CFG_W-1:0]        count_reg, count_next;
    logic [TB-1:0]           now_reg, now_next;
    logic                    tstart_reg, tstart_next;
    phase_t                  phase_reg [MAX_PROCS];
    phase_t                  phase_next [MAX_PROCS];
    logic                    started_reg [MAX_PROCS];
    logic                    started_next [MAX_PROCS];
    logic                    out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0]   out_data_reg, out_data_next;
    logic                    out_idle_reg, out_idle_next;

    logic                    accept;
    logic [3:0]              in_slot;
    logic [IDX_W-1:0]        slot_idx;
    logic                    slot_ok;
    logic [EW-1:0]           load_entry;
    logic [CNT_W-1:0]        act_n;
    logic [CW-1:0]           cfg_ext;

    logic                    mem_we;
    logic [IDX_W-1:0]        mem_waddr;
    logic [EW-1:0]           mem_wdata;
    logic [EW-1:0]           mem_rdata;

    pick_ctl_t               pctl;
    logic                    p_found;
    logic [IDX_W-1:0]        p_idx;
    logic [EW-1:0]           p_entry;
    phase_t                  p_phase;
    logic                    p_started;
    logic [CNT_W-1:0]        p_unf;
    logic [TB-1:0]           p_min;

    logic [TB-1:0]           b_ready, b_rem1, b_rem2, b_wait;
    logic [TB-1:0]           next_t, new_ready, resp;
    logic [TB:0]             ready_sum;
    logic [EW-1:0]           upd_entry;
    phase_t                  upd_phase;
    logic                    fin, first;
    logic                    all_done;
    logic [3:0]              run_idx;
    logic [31:0]             best_ext;

    // Input field decode
    assign in_slot    = s_tdata[3:0];
    assign slot_idx   = IDX_W'(in_slot);
    assign slot_ok    = 32'(in_slot) < 32'(MAX_PROCS);
    assign load_entry = {sat_in(s_tdata[51:36]), sat_in(s_tdata[67:52]),
                         sat_in(s_tdata[35:20]), sat_in(s_tdata[19:4])};
    // entry layout from bit 0: ready_at, remaining_first, remaining_second,
    // wait_ticks
    assign accept     = s_tvalid && s_tready;
    assign s_tready   = (state_reg == S_IDLE);
    assign cfg_ready  = 1'b1;

    // Active entry count, capped at the table depth
    assign cfg_ext = CW'(count_reg);
    assign act_n   = (cfg_ext > CW'(MAX_PROCS)) ? CNT_W'(MAX_PROCS) : CNT_W'(cfg_ext);

    // Table RAM
    srbs_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_PROCS)
    ) u_table (
        .clk   (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (cnt_reg[IDX_W-1:0]),
        .rdata (mem_rdata)
    );

    // Selection unit
    srbs_pick #(
        .TIME_BITS (TB),
        .IDX_W     (IDX_W),
        .CNT_W     (CNT_W)
    ) u_pick (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .ctl          (pctl),
        .now          (now_reg),
        .idx          (beat_idx_reg),
        .entry        (mem_rdata),
        .phase        (phase_reg[beat_idx_reg]),
        .started      (started_reg[beat_idx_reg]),
        .found        (p_found),
        .best_idx     (p_idx),
        .best_entry   (p_entry),
        .best_phase   (p_phase),
        .best_started (p_started),
        .unf_cnt      (p_unf),
        .min_ready    (p_min)
    );

    // Run one tick of the chosen entry
    assign b_ready   = p_entry[TB-1:0];
    assign b_rem1    = p_entry[2*TB-1:TB];
    assign b_rem2    = p_entry[3*TB-1:2*TB];
    assign b_wait    = p_entry[4*TB-1:3*TB];
    assign next_t    = (now_reg == TMAX) ? TMAX : now_reg + TB'(1);
    assign ready_sum = {1'b0, next_t} + {1'b0, b_wait};
    assign new_ready = ready_sum[TB] ? TMAX : ready_sum[TB-1:0];
    assign resp      = now_reg - b_ready;
    assign first     = p_found && !p_started;

    always_comb begin
        upd_entry = p_entry;
        upd_phase = p_phase;
        fin       = 1'b0;
        if (p_phase == PH_FIRST) begin
            if (b_rem1 <= TB'(1)) begin
                upd_entry[2*TB-1:TB] = '0;
                upd_entry[TB-1:0]    = new_ready;
                upd_phase            = PH_SECOND;
            end else begin
                upd_entry[2*TB-1:TB] = b_rem1 - TB'(1);
            end
        end else begin
            if (b_rem2 <= TB'(1)) begin
                upd_entry[3*TB-1:2*TB] = '0;
                upd_phase              = PH_DONE;
                fin                    = p_found;
            end else begin
                upd_entry[3*TB-1:2*TB] = b_rem2 - TB'(1);
            end
        end
    end

    assign all_done = (p_unf - CNT_W'(fin)) == '0;
    assign best_ext = 32'(p_idx);
    assign run_idx  = p_found ? best_ext[3:0] : 4'd0;

    // Sequencer next state
    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        beat_next      = beat_reg;
        beat_idx_next  = beat_idx_reg;
        count_next     = count_reg;
        now_next       = now_reg;
        tstart_next    = tstart_reg;
        phase_next     = phase_reg;
        started_next   = started_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_idle_next  = out_idle_reg;
        mem_we         = 1'b0;
        mem_waddr      = slot_idx;
        mem_wdata      = load_entry;
        pctl           = '0;

        if (cfg_valid && cfg_ready) begin
            count_next = cfg_data;
        end
        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    if (s_tuser == OP_LOAD) begin
                        if (slot_ok) begin
                            mem_we                 = 1'b1;
                            phase_next[slot_idx]   = PH_FIRST;
                            started_next[slot_idx] = 1'b0;
                            tstart_next            = 1'b0;
                        end
                    end else begin
                        cnt_next   = '0;
                        beat_next  = 1'b0;
                        pctl.clear = 1'b1;
                        if (!tstart_reg && act_n != '0) begin
                            state_next = S_MIN;
                        end else begin
                            tstart_next = 1'b1;
                            state_next  = S_SCAN;
                        end
                    end
                end
            end
            S_MIN, S_SCAN: begin
                pctl.beat     = beat_reg;
                pctl.find_min = (state_reg == S_MIN);
                if (cnt_reg < act_n) begin
                    cnt_next      = cnt_reg + CNT_W'(1);
                    beat_next     = 1'b1;
                    beat_idx_next = cnt_reg[IDX_W-1:0];
                end else begin
                    beat_next = 1'b0;
                    if (!beat_reg) begin
                        if (state_reg == S_MIN) begin
                            now_next    = p_min;
                            tstart_next = 1'b1;
                            cnt_next    = '0;
                            pctl.clear  = 1'b1;
                            state_next  = S_SCAN;
                        end else begin
                            state_next = S_UPD;
                        end
                    end
                end
            end
            S_UPD: begin
                if (!out_valid_reg || m_tready) begin
                    if (p_found) begin
                        mem_we              = 1'b1;
                        mem_waddr           = p_idx;
                        mem_wdata           = upd_entry;
                        phase_next[p_idx]   = upd_phase;
                        started_next[p_idx] = 1'b1;
                    end
                    now_next       = next_t;
                    out_valid_next = 1'b1;
                    out_idle_next  = !p_found;
                    out_data_next  = {1'b0, all_done,
                                      fin ? to16(next_t) : 16'd0, fin,
                                      first ? to16(resp) : 16'd0, first,
                                      run_idx, to16(now_reg)};
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // State and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            beat_reg      <= 1'b0;
            beat_idx_reg  <= '0;
            count_reg     <= CFG_W'(1);
            now_reg       <= '0;
            tstart_reg    <= 1'b0;
            for (int i = 0; i < MAX_PROCS; i++) begin
                phase_reg[i]   <= PH_FIRST;
                started_reg[i] <= 1'b0;
            end
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            out_idle_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            beat_reg      <= beat_next;
            beat_idx_reg  <= beat_idx_next;
            count_reg     <= count_next;
            now_reg       <= now_next;
            tstart_reg    <= tstart_next;
            phase_reg     <= phase_next;
            started_reg   <= started_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
            out_idle_reg  <= out_idle_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_idle_reg;

endmodule

// ----- hdl/srbs_check.sv -----
// ----------------------------------------------------------------------------
// srbs_check
// Port-level checks on the scheduler's result stream.
// ----------------------------------------------------------------------------
module srbs_check
    import srbs_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic [OUT_DATA_W-1:0] m_tdata,
    input logic                  m_tuser,
    input logic                  m_tvalid,
    input logic                  m_tready
);

    // A stalled item stays put
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result item changed while stalled");

    // Idle tick runs nothing, dispatches nothing, finishes nothing
    a_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[19:16] == 4'd0 && !m_tdata[20] && !m_tdata[37])
        else $error("idle tick carries a run");

    // Response time only with a first dispatch
    a_resp: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[20] |-> m_tdata[36:21] == 16'd0)
        else $error("response time without first dispatch");

    // Finish time only with a finished process
    a_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[37] |-> m_tdata[53:38] == 16'd0)
        else $error("finish time without finish");

endmodule

bind shortest_remaining_burst_scheduler srbs_check u_check (.*);

// ----- tb/sv/srbs_monitor.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srbs_monitor
// Watches the load/tick, result and process_count channels of the scheduler.
// Keeps its own copy of the process table, predicts one tick report per
// accepted tick item and compares the reports in order, field by field.
// ----------------------------------------------------------------------------
module srbs_monitor
    import srbs_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic                  s_tuser,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [OUT_DATA_W-1:0] m_tdata,
    input  logic                  m_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [CFG_W-1:0]      cfg_data,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    output int                    error_count,
    output int                    pending_reports
);

    localparam int          SLOTS    = 16;
    localparam logic [15:0] TIME_MAX = 16'hFFFF;

    // One tick report, as the block presents it
    typedef struct packed {
        logic [15:0] tick_time;
        logic [3:0]  run_index;
        logic        idle;
        logic        first_dispatch;
        logic [15:0] response_time;
        logic        finished;
        logic [15:0] finish_time;
        logic        all_done;
    } tick_report_t;

    // Shadow process table
    logic [15:0]     ready_at    [SLOTS];
    logic [15:0]     rem_first   [SLOTS];
    logic [15:0]     rem_second  [SLOTS];
    logic [15:0]     io_wait     [SLOTS];
    phase_t          burst_phase [SLOTS];
    logic            started     [SLOTS];
    logic [15:0]     now_time;
    logic            clock_set;
    logic [CFG_W-1:0] proc_count;

    tick_report_t report_q [$];
    int           mismatches = 0;

    // Load one table entry
    function automatic void load_entry(input logic [IN_DATA_W-1:0] d);
        int s;
        s = int'(d[3:0]);
        ready_at[s]    = d[19:4];
        rem_first[s]   = d[35:20];
        io_wait[s]     = d[51:36];
        rem_second[s]  = d[67:52];
        burst_phase[s] = PH_FIRST;
        started[s]     = 1'b0;
        clock_set      = 1'b0;
    endfunction

    // Advance one scheduling tick and build its report
    function automatic tick_report_t schedule_tick();
        tick_report_t r;
        int           n;
        int           i;
        int           best;
        logic         found;
        logic [15:0]  best_rem;
        logic [15:0]  rem;
        logic [15:0]  earliest;
        logic [15:0]  next_time;
        logic [16:0]  wake;
        r     = '0;
        n     = (proc_count > SLOTS) ? SLOTS : int'(proc_count);
        found = 1'b0;
        best  = 0;
        best_rem = '0;

        // time begins at the earliest arrival after reset or a load
        if (!clock_set) begin
            if (n > 0) begin
                earliest = TIME_MAX;
                for (i = 0; i < n; i++)
                    if (ready_at[i] < earliest) earliest = ready_at[i];
                now_time = earliest;
            end
            clock_set = 1'b1;
        end
        next_time = (now_time == TIME_MAX) ? TIME_MAX : now_time + 16'd1;

        // least remaining burst among ready entries, lowest index on ties
        for (i = 0; i < n; i++) begin
            if (burst_phase[i] == PH_DONE || ready_at[i] > now_time) continue;
            rem = (burst_phase[i] == PH_FIRST) ? rem_first[i] : rem_second[i];
            if (!found || rem < best_rem) begin
                found    = 1'b1;
                best     = i;
                best_rem = rem;
            end
        end

        r.tick_time = now_time;
        r.idle      = !found;
        if (found) begin
            r.run_index = 4'(best);
            if (!started[best]) begin
                started[best]    = 1'b1;
                r.first_dispatch = 1'b1;
                r.response_time  = now_time - ready_at[best];
            end
            if (burst_phase[best] == PH_FIRST) begin
                if (rem_first[best] <= 16'd1) begin
                    // first burst over, back after the I/O wait
                    rem_first[best]   = '0;
                    burst_phase[best] = PH_SECOND;
                    wake = {1'b0, next_time} + {1'b0, io_wait[best]};
                    ready_at[best] = wake[16] ? TIME_MAX : wake[15:0];
                end else begin
                    rem_first[best] = rem_first[best] - 16'd1;
                end
            end else begin
                if (rem_second[best] <= 16'd1) begin
                    rem_second[best]  = '0;
                    burst_phase[best] = PH_DONE;
                    r.finished        = 1'b1;
                    r.finish_time     = next_time;
                end else begin
                    rem_second[best] = rem_second[best] - 16'd1;
                end
            end
        end
        now_time = next_time;

        r.all_done = 1'b1;
        for (i = 0; i < n; i++)
            if (burst_phase[i] != PH_DONE) r.all_done = 1'b0;
        return r;
    endfunction

    function automatic void check_field(input string label, input logic [15:0] want,
                                        input logic [15:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, label,
                         want, got);
        end
    endfunction

    // Channel watch, prediction and compare
    always @(posedge aclk) begin
        tick_report_t want;
        tick_report_t got;
        int           i;
        if (!aresetn) begin
            for (i = 0; i < SLOTS; i++) begin
                ready_at[i]    = '0;
                rem_first[i]   = '0;
                rem_second[i]  = '0;
                io_wait[i]     = '0;
                burst_phase[i] = PH_FIRST;
                started[i]     = 1'b0;
            end
            now_time   = '0;
            clock_set  = 1'b0;
            proc_count = CFG_W'(1);
            report_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) proc_count = cfg_data;

            if (s_tvalid && s_tready) begin
                if (s_tuser == OP_LOAD) load_entry(s_tdata);
                else report_q.push_back(schedule_tick());
            end

            if (m_tvalid && m_tready) begin
                got = {m_tdata[15:0], m_tdata[19:16], m_tuser, m_tdata[20],
                       m_tdata[36:21], m_tdata[37], m_tdata[53:38], m_tdata[54]};
                if (report_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected result item, tick_time %0d", $realtime,
                                 got.tick_time);
                end else begin
                    want = report_q.pop_front();
                    check_field("tick_time", want.tick_time, got.tick_time);
                    check_field("run_index", 16'(want.run_index), 16'(got.run_index));
                    check_field("idle", 16'(want.idle), 16'(got.idle));
                    check_field("first_dispatch", 16'(want.first_dispatch),
                                16'(got.first_dispatch));
                    check_field("response_time", want.response_time, got.response_time);
                    check_field("finished", 16'(want.finished), 16'(got.finished));
                    check_field("finish_time", want.finish_time, got.finish_time);
                    check_field("all_done", 16'(want.all_done), 16'(got.all_done));
                end
            end
        end
        pending_reports <= report_q.size();
        error_count     <= mismatches;
    end

endmodule

// ----- tb/sv/tb_shortest_remaining_burst_scheduler.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_shortest_remaining_burst_scheduler
// Stimulus and verdict for the shortest-remaining-burst scheduler.
// A directed opening loads every slot and walks saturation, one-tick bursts,
// idle ticks and the all-done state; then phases of random workloads run
// under several process counts and source/sink throttling modes. The
// monitor beside the block predicts and compares every tick report.
// ----------------------------------------------------------------------------
module tb_shortest_remaining_burst_scheduler;
    import srbs_pkg::*;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic                  s_tuser   = OP_LOAD;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [CFG_W-1:0]      cfg_data  = '0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;

    int error_count;
    int pending_reports;
    int gap_pct    = 0;
    int stall_pct  = 0;
    int items_sent = 0;

    shortest_remaining_burst_scheduler uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_data  (cfg_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready)
    );

    srbs_monitor sched_chk (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .cfg_data        (cfg_data),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .error_count     (error_count),
        .pending_reports (pending_reports)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Result sink with random back-pressure
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Present one item and hold it until accepted
    task automatic push_item(input logic op, input logic [IN_DATA_W-1:0] data);
        while ($urandom_range(99) < gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= data;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
    endtask

    task automatic load_slot(input logic [3:0] slot, input logic [15:0] arrival,
                             input logic [15:0] first_burst, input logic [15:0] wait_io,
                             input logic [15:0] second_burst);
        push_item(OP_LOAD, {4'b0, second_burst, wait_io, first_burst, arrival, slot});
    endtask

    // Tick payload is don't-care; fill it with noise
    task automatic tick();
        logic [IN_DATA_W-1:0] noise;
        noise[31:0]  = $urandom;
        noise[63:32] = $urandom;
        noise[71:64] = 8'($urandom_range(255));
        push_item(OP_TICK, noise);
    endtask

    // Mostly small times, now and then anything the field holds
    function automatic logic [15:0] pick_time(input int small_max);
        if ($urandom_range(9) == 0) return 16'($urandom_range(65535));
        return 16'($urandom_range(small_max));
    endfunction

    // Let all reports drain and the block settle, then write process_count
    task automatic set_process_count(input logic [CFG_W-1:0] count);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_reports != 0) @(posedge aclk);
        repeat (45) @(posedge aclk);
        cfg_data  <= count;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Load the active slots, each skipped now and then, then tick roughly until all finish
    task automatic run_workload(input int n);
        int          i;
        int          k;
        int          budget;
        int          ticks;
        logic [15:0] fb;
        logic [15:0] sb;
        budget = 40;
        for (i = 0; i < n; i++) begin
            if ($urandom_range(9) == 0) continue;
            fb = pick_time(4);
            sb = pick_time(4);
            budget += ((fb == 0) ? 1 : int'(fb)) + ((sb == 0) ? 1 : int'(sb));
            load_slot(4'(i), pick_time(30), fb, pick_time(10), sb);
        end
        ticks = (n == 0) ? $urandom_range(3, 10) : ((budget > 150) ? 150 : budget);
        for (k = 0; k < ticks; k++) begin
            // occasional reload mid-run restarts the time base
            if ($urandom_range(29) == 0)
                load_slot(4'($urandom_range(15)), pick_time(60), pick_time(4),
                          pick_time(10), pick_time(4));
            tick();
        end
    endtask

    initial begin
        int i;
        int p;
        int count;
        int phase_start;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: saturated time, one-tick bursts, all slots written
        load_slot(4'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0);
        for (i = 1; i < 15; i++)
            load_slot(4'(i), 16'($urandom_range(65535)), 16'($urandom_range(65535)),
                      16'($urandom_range(65535)), 16'($urandom_range(65535)));
        load_slot(4'd15, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        repeat (3) tick();
        // I/O wait leaves nothing ready for a few ticks
        load_slot(4'd0, 16'd0, 16'd1, 16'd3, 16'd1);
        repeat (5) tick();

        // Random phases over counts and throttling modes
        p = 0;
        while (items_sent < 1025 || p < 8) begin
            case (p)
                0:       count = 16;
                1:       count = 0;
                2:       count = 31;
                3:       count = 1;
                4:       count = 17;
                5:       count = 2;
                default: count = ($urandom_range(3) == 0) ? $urandom_range(17, 31)
                                                         : $urandom_range(1, 16);
            endcase
            set_process_count(CFG_W'(count));
            case (p % 4)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 49; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 49; end
                default: begin gap_pct = 32; stall_pct = 32; end
            endcase
            phase_start = items_sent;
            while (items_sent - phase_start < 110)
                run_workload((count > 16) ? 16 : count);
            p++;
        end

        // Drain and settle
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_reports != 0) @(posedge aclk);
        repeat (45) @(posedge aclk);
        if (error_count == 0 && pending_reports == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #10_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
